FILE: hw/rtl/rrrl_pkg.sv
package rrrl_pkg;

    // Width of the task number field on the input side.
    localparam int TASK_ID_W = 8;

    // Width of the opcode and status fields.
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 3;

    // Operation codes carried with each input transfer.
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NEXT   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // Status codes returned with each result transfer.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_PRESENT = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_ABSENT  = 3'd4
    } status_t;

endpackage

FILE: hw/rtl/round_robin_ready_list_unit.sv
// Channel | Direction | tdata (lowest bit up)               | tuser
// s_      | in        | task_id[7:0]                        | opcode[1:0]
// m_      | out       | next_task[NW-1:0], status[2:0], pad | none
//
// One item is in work at a time; s_tready is high only while the sequencer is idle.
// Remove can run longest, as its time is set by the predecessor
// scan through the single read port of the successor table.
// Reset clears the valid bits and the tail at once; no clearing pass is needed.
// A finished result waits in the output register while the next item is accepted.
module round_robin_ready_list_unit #(
    parameter int MAX_TASKS = 16,
    localparam int NW = $clog2(MAX_TASKS + 1),
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int OUT_W = ((NW + rrrl_pkg::STATUS_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rrrl_pkg::TASK_ID_W-1:0] s_tdata,  // task_id
    input  logic [rrrl_pkg::OPCODE_W-1:0]  s_tuser,  // opcode
    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata    // next_task, status, zero pad
);

    localparam logic [NW-1:0] NONE = NW'(MAX_TASKS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_TASKS - 1);
    localparam int PAD_W = OUT_W - NW - rrrl_pkg::STATUS_W;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_NEXT_RD  = 11'b000_0000_0100,
        S_ADD_CHK  = 11'b000_0000_1000,
        S_ADD_LINK = 11'b000_0001_0000,
        S_ADD_TAIL = 11'b000_0010_0000,
        S_REM_CHK  = 11'b000_0100_0000,
        S_REM_SOLE = 11'b000_1000_0000,
        S_SCAN     = 11'b001_0000_0000,
        S_REM_CLR  = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    state_t                         state_reg, state_next;
    rrrl_pkg::opcode_t              op_reg, op_next;
    logic [rrrl_pkg::TASK_ID_W-1:0] id_reg, id_next;
    logic [NW-1:0]                  tail_reg, tail_next;
    logic [NW-1:0]                  link_reg, link_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    rrrl_pkg::status_t              res_status_reg, res_status_next;
    logic [NW-1:0]                  res_task_reg, res_task_next;
    logic                           m_valid_reg, m_valid_next;
    rrrl_pkg::status_t              out_status_reg;
    logic [NW-1:0]                  out_task_reg;
    logic                           out_load;

    // Successor table, its valid bits and the registered read port.
    logic [NW-1:0]                  succ_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0]           valid_reg;
    logic [NW-1:0]                  rd_data_reg;
    logic                           rd_vld_reg;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [NW-1:0]                  wr_data;
    logic [NW-1:0]                  entry;

    // Derived views of the held item.
    logic                           id_out_of_range;
    logic [AW-1:0]                  id_addr;
    logic [NW-1:0]                  id_ent;
    logic [AW-1:0]                  tail_addr;
    logic                           tail_empty;

    assign id_out_of_range = ({1'b0, id_reg} >= (rrrl_pkg::TASK_ID_W + 1)'(MAX_TASKS));
    assign id_addr         = AW'(id_reg);
    assign id_ent          = NW'(id_addr);
    assign tail_addr       = tail_reg[AW-1:0];
    assign tail_empty      = (tail_reg == NONE);
    assign entry           = rd_vld_reg ? rd_data_reg : NONE;

    // Table storage: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            succ_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= succ_mem[rd_addr];
    end

    // Valid bits make an entry that was never written read as none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        tail_next       = tail_reg;
        link_next       = link_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_task_next   = res_task_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = id_addr;
        wr_data         = NONE;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = rrrl_pkg::opcode_t'(s_tuser);
                    id_next    = s_tdata;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_task_next   = NONE;
                res_status_next = rrrl_pkg::ST_OK;
                state_next      = S_DONE;
                case (op_reg)
                    rrrl_pkg::OP_ADD:
                    begin
                        if (id_out_of_range)
                        begin
                            res_status_next = rrrl_pkg::ST_RANGE;
                        end
                        else if (tail_empty)
                        begin
                            // First task links to itself.
                            wr_en     = 1'b1;
                            wr_addr   = id_addr;
                            wr_data   = id_ent;
                            tail_next = id_ent;
                        end
                        else
                        begin
                            rd_addr    = id_addr;
                            state_next = S_ADD_CHK;
                        end
                    end
                    rrrl_pkg::OP_REMOVE:
                    begin
                        if (id_out_of_range)
                        begin
                            res_status_next = rrrl_pkg::ST_RANGE;
                        end
                        else if (tail_empty)
                        begin
                            res_status_next = rrrl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_addr    = id_addr;
                            state_next = S_REM_CHK;
                        end
                    end
                    rrrl_pkg::OP_NEXT:
                    begin
                        if (tail_empty)
                        begin
                            res_status_next = rrrl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_addr    = tail_addr;
                            state_next = S_NEXT_RD;
                        end
                    end
                    default:
                    begin
                        res_status_next = rrrl_pkg::ST_OK;
                    end
                endcase
            end

            S_NEXT_RD:
            begin
                tail_next     = entry;
                res_task_next = entry;
                state_next    = S_DONE;
            end

            S_ADD_CHK:
            begin
                if (entry != NONE)
                begin
                    res_status_next = rrrl_pkg::ST_PRESENT;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_addr    = tail_addr;
                    state_next = S_ADD_LINK;
                end
            end

            S_ADD_LINK:
            begin
                // New task inherits the tail's successor.
                wr_en      = 1'b1;
                wr_addr    = id_addr;
                wr_data    = entry;
                state_next = S_ADD_TAIL;
            end

            S_ADD_TAIL:
            begin
                wr_en      = 1'b1;
                wr_addr    = tail_addr;
                wr_data    = id_ent;
                tail_next  = id_ent;
                state_next = S_DONE;
            end

            S_REM_CHK:
            begin
                if (entry == NONE)
                begin
                    res_status_next = rrrl_pkg::ST_ABSENT;
                    state_next      = S_DONE;
                end
                else
                begin
                    link_next  = entry;
                    rd_addr    = tail_addr;
                    state_next = S_REM_SOLE;
                end
            end

            S_REM_SOLE:
            begin
                if (entry == tail_reg)
                begin
                    // Sole task: the list becomes empty.
                    wr_en      = 1'b1;
                    wr_addr    = tail_addr;
                    wr_data    = NONE;
                    tail_next  = NONE;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = '0;
                    rd_addr    = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Entry idx is on the read port; the next entry is fetched meanwhile.
                rd_addr = idx_reg + AW'(1);
                if (entry == id_ent)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = link_reg;
                    state_next = S_REM_CLR;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_REM_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = id_addr;
                wr_data = NONE;
                if (tail_reg == id_ent)
                begin
                    tail_next = NW'(idx_reg);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: a new result loads once the previous transfer has gone.
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tail_reg    <= NONE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        link_reg       <= link_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_task_reg   <= res_task_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_task_reg   <= res_task_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_status_reg, out_task_reg};

`ifndef SYNTHESIS
    a_state_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_tail_range : assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= NONE)
        else $error("tail pointer beyond the task range");

    a_tail_written : assert property (@(posedge clk) disable iff (!rst_n)
        !tail_empty |-> valid_reg[tail_addr])
        else $error("tail points at a table entry never written");

    a_accept_decode : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DECODE))
        else $error("accepted transfer did not start decoding");

    a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result loaded over an untaken transfer");
`endif

endmodule

FILE: dv/round_robin_ready_list_unit_test.sv
module round_robin_ready_list_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASKS = 16;
    localparam int NEXT_W = 5;
    localparam int OUT_W = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [NEXT_W-1:0] NO_TASK = NEXT_W'(TASKS);

    // One expected result transfer.
    typedef struct {
        logic [NEXT_W-1:0] next_task;
        rrrl_pkg::status_t status;
    } list_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [rrrl_pkg::TASK_ID_W-1:0] s_tdata = '0;
    logic [rrrl_pkg::OPCODE_W-1:0]  s_tuser = rrrl_pkg::OP_ADD;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    // Own copy of the ready list, advanced at every accepted input transfer.
    logic [NEXT_W-1:0]   successor_of [TASKS];
    logic [NEXT_W-1:0]   tail_task;
    list_result_t        pending_results [$];

    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    int                  burst_left = 0;
    bit                  sender_gaps = 1'b0;
    int                  rx_hold_cycles = 0;
    logic [6:0]          rx_phase = '0;

    round_robin_ready_list_unit #(
        .MAX_TASKS(TASKS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // Apply one scheduler call to the local list and return what the block should answer.
    function automatic list_result_t apply_list_call(rrrl_pkg::opcode_t op, logic [7:0] id);
        list_result_t res;
        bit           found;
        res.next_task = NO_TASK;
        res.status = rrrl_pkg::ST_OK;
        found = 1'b0;
        case (op)
            rrrl_pkg::OP_ADD:
            begin
                if (id >= TASKS)
                    res.status = rrrl_pkg::ST_RANGE;
                else if (tail_task == NO_TASK)
                begin
                    tail_task = NEXT_W'(id);
                    successor_of[id] = NEXT_W'(id);
                end
                else if (successor_of[id] != NO_TASK)
                    res.status = rrrl_pkg::ST_PRESENT;
                else
                begin
                    successor_of[id] = successor_of[tail_task];
                    successor_of[tail_task] = NEXT_W'(id);
                    tail_task = NEXT_W'(id);
                end
            end
            rrrl_pkg::OP_REMOVE:
            begin
                if (id >= TASKS)
                    res.status = rrrl_pkg::ST_RANGE;
                else if (tail_task == NO_TASK)
                    res.status = rrrl_pkg::ST_EMPTY;
                else if (successor_of[id] == NO_TASK)
                    res.status = rrrl_pkg::ST_ABSENT;
                else if (successor_of[tail_task] == tail_task)
                begin
                    // The only task in the list goes, so the list becomes empty.
                    successor_of[tail_task] = NO_TASK;
                    tail_task = NO_TASK;
                end
                else
                begin
                    // The lowest entry that points at the task is its predecessor.
                    for (int i = 0; i < TASKS; i++)
                    begin
                        if (!found && successor_of[i] == NEXT_W'(id))
                        begin
                            found = 1'b1;
                            successor_of[i] = successor_of[id];
                            successor_of[id] = NO_TASK;
                            if (tail_task == NEXT_W'(id))
                                tail_task = NEXT_W'(i);
                        end
                    end
                end
            end
            rrrl_pkg::OP_NEXT:
            begin
                if (tail_task == NO_TASK)
                    res.status = rrrl_pkg::ST_EMPTY;
                else
                begin
                    tail_task = successor_of[tail_task];
                    res.next_task = tail_task;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Pick a valid task number that is, or is not, in the list, if one can be found.
    function automatic logic [7:0] pick_task(bit want_listed);
        logic [7:0] cand;
        cand = 8'($urandom_range(0, TASKS - 1));
        for (int n = 0; n < 4 * TASKS; n++)
        begin
            if ((successor_of[cand] != NO_TASK) == want_listed)
                return cand;
            cand = 8'($urandom_range(0, TASKS - 1));
        end
        return cand;
    endfunction

    // Offer one item, wait for its transfer and record the expected answer.
    task automatic send_item(rrrl_pkg::opcode_t op, logic [7:0] id);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(0, 9);
            burst_left = $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = id;
        s_tuser = op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_list_call(op, id));
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Calls on an empty list, out-of-range numbers and the unused opcode.
    task automatic test_empty_list();
        send_item(rrrl_pkg::OP_NEXT, 8'h00);
        send_item(rrrl_pkg::OP_REMOVE, 8'd3);
        send_item(rrrl_pkg::OP_REMOVE, 8'hFF);
        send_item(rrrl_pkg::OP_ADD, 8'd16);
        send_item(rrrl_pkg::OP_ADD, 8'hFF);
        send_item(rrrl_pkg::OP_NONE, 8'hA5);
    endtask

    // Linking and unlinking: sole task, duplicates, absent tasks and removal of the tail.
    task automatic test_add_and_remove();
        send_item(rrrl_pkg::OP_ADD, 8'd0);
        send_item(rrrl_pkg::OP_ADD, 8'd0);
        send_item(rrrl_pkg::OP_NEXT, 8'h3C);
        send_item(rrrl_pkg::OP_REMOVE, 8'd0);
        send_item(rrrl_pkg::OP_NEXT, 8'hC3);
        send_item(rrrl_pkg::OP_ADD, 8'd15);
        send_item(rrrl_pkg::OP_ADD, 8'd0);
        send_item(rrrl_pkg::OP_ADD, 8'd7);
        send_item(rrrl_pkg::OP_REMOVE, 8'd3);
        send_item(rrrl_pkg::OP_NEXT, 8'h00);
        send_item(rrrl_pkg::OP_NEXT, 8'hFF);
        send_item(rrrl_pkg::OP_REMOVE, 8'd7);
        send_item(rrrl_pkg::OP_REMOVE, 8'd0);
        send_item(rrrl_pkg::OP_NEXT, 8'h81);
        send_item(rrrl_pkg::OP_REMOVE, 8'd15);
        send_item(rrrl_pkg::OP_NONE, 8'h5A);
    endtask

    // Mostly well-formed calls on random tasks, with the add share drifting so that the
    // list swings between empty and full; the rest are noise and out-of-range numbers.
    task automatic test_random_traffic(int n_items);
        int                add_share;
        int                pick;
        rrrl_pkg::opcode_t op;
        logic [7:0]        id;
        add_share = 50;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 60 == 0)
                add_share = $urandom_range(15, 75);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = rrrl_pkg::OP_NONE;
            else if (pick < 3 + add_share * 97 / 100)
                op = rrrl_pkg::OP_ADD;
            else if ($urandom_range(0, 1) == 0)
                op = rrrl_pkg::OP_REMOVE;
            else
                op = rrrl_pkg::OP_NEXT;
            if (op == rrrl_pkg::OP_NEXT || op == rrrl_pkg::OP_NONE)
                id = 8'($urandom);
            else if ($urandom_range(0, 99) < 8)
                id = 8'($urandom_range(TASKS, 255));
            else if ($urandom_range(0, 99) < 75)
                id = pick_task(op == rrrl_pkg::OP_REMOVE);
            else
                id = 8'($urandom_range(0, TASKS - 1));
            send_item(op, id);
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming back to back,
    // then the sender pauses until the block has drained.
    task automatic test_output_stall();
        sender_gaps = 1'b0;
        rx_hold_cycles = 300;
        test_random_traffic(24);
        wait_for_results();
    endtask

    // Receiver: a long hold-off when asked, otherwise windows of steady readiness
    // alternating with light and heavy random stalls.
    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            m_tready = 1'b0;
            rx_hold_cycles--;
        end
        else
        begin
            rx_phase++;
            case (rx_phase[6:5])
                2'd0: m_tready = 1'b1;
                2'd3: m_tready = ($urandom_range(0, 4) == 0);
                default: m_tready = ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        logic [NEXT_W-1:0] got_next;
        logic [2:0]        got_status;
        list_result_t      want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_next = m_tdata[NEXT_W-1:0];
            got_status = m_tdata[NEXT_W+2:NEXT_W];
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected result next_task=%0d status=%0d",
                             $realtime, got_next, got_status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got_next !== want.next_task || got_status !== want.status)
                begin
                    if (mismatches < 10)
                        $display("%0t: next_task exp %0d got %0d, status exp %0d got %0d",
                                 $realtime, want.next_task, got_next, want.status,
                                 got_status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        for (int i = 0; i < TASKS; i++)
            successor_of[i] = NO_TASK;
        tail_task = NO_TASK;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_add_and_remove();
        test_output_stall();
        sender_gaps = 1'b1;
        test_random_traffic(600);

        wait_for_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
